// ----- rtl/assert_macros.svh -----
// Assertion macros for the files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property on clk, ignored while arst_n is low
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same-cycle implication on clk
`define ASSERT_IMPL(label, ante, cons, msg) \
	`ASSERT_CLK(label, (ante) |-> (cons), msg)

`endif

// ----- rtl/sip_pkg.sv -----
// Package for the segment intersection block: widths and pipeline payload types.
package sip_pkg;

	// Field widths
	localparam int COORD_W = 24;
	localparam int EPS_W   = 16;
	localparam logic [EPS_W-1:0] EPS_RESET = 16'd1;

	// Derived datapath widths
	localparam int DIFF_W  = COORD_W + 1;       // coordinate difference
	localparam int PROD_W  = 2 * DIFF_W;        // one cross product term
	localparam int NUM_W   = PROD_W + 1;        // denominator and numerators
	localparam int MAG_W   = NUM_W;             // their magnitudes
	localparam int QW      = DIFF_W + EPS_W;    // quotient bits
	localparam int N_W     = MAG_W + DIFF_W;    // dividend |t_numer| * |s|
	localparam int PP_LO_W = (MAG_W + 1) / 2;   // split of |t_numer| for the multiply
	localparam int PP_HI_W = MAG_W - PP_LO_W;
	localparam int PPL_W   = PP_LO_W + DIFF_W;
	localparam int PPH_W   = PP_HI_W + DIFF_W;
	localparam int OFF_W   = QW + 1;            // signed offset along segment one
	localparam int SUM_W   = OFF_W + 1;         // p0 plus offset, before saturation

	// One axis of the restoring divider: partial remainder and dividend/quotient word
	typedef struct packed {
		logic [MAG_W-1:0] rem;
		logic [QW-1:0]    work;
	} lane_t;

	// Payload travelling down the divider stages
	typedef struct packed {
		lane_t                     lx;
		lane_t                     ly;
		logic [MAG_W-1:0]          dm;
		logic                      neg_x;
		logic                      neg_y;
		logic                      hit;
		logic signed [COORD_W-1:0] x0;
		logic signed [COORD_W-1:0] y0;
	} div_t;

endpackage

// ----- rtl/sip_ifs.sv -----
// Channel interfaces: segment pair input, result output and configuration write.
interface sip_pair_if import sip_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] first_start_x;
	logic signed [COORD_W-1:0] first_start_y;
	logic signed [COORD_W-1:0] first_end_x;
	logic signed [COORD_W-1:0] first_end_y;
	logic signed [COORD_W-1:0] second_start_x;
	logic signed [COORD_W-1:0] second_start_y;
	logic signed [COORD_W-1:0] second_end_x;
	logic signed [COORD_W-1:0] second_end_y;

	modport source (
		output valid, first_start_x, first_start_y, first_end_x, first_end_y,
		output second_start_x, second_start_y, second_end_x, second_end_y,
		input  ready
	);
	modport sink (
		input  valid, first_start_x, first_start_y, first_end_x, first_end_y,
		input  second_start_x, second_start_y, second_end_x, second_end_y,
		output ready
	);
endinterface

interface sip_result_if import sip_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic                      hit;
	logic signed [COORD_W-1:0] cross_x;
	logic signed [COORD_W-1:0] cross_y;

	modport source (output valid, hit, cross_x, cross_y, input ready);
	modport sink (input valid, hit, cross_x, cross_y, output ready);
endinterface

interface sip_cfg_if import sip_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [EPS_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ----- rtl/segment_intersection_point.sv -----
// Top level of the segment intersection block: front pipeline, divider chain, output.
//
// Usage
//   pair   : valid/ready channel carrying the two segments p0-p1 and p2-p3.
//   result : valid/ready channel carrying hit, cross_x and cross_y, one per pair.
//   cfg    : valid/ready write of edge_epsilon; always ready, write only when idle.
// Throughput: one pair per cycle, sustained, as long as result.ready stays high.
// Pipeline: six front stages form the products and tests, one restoring-division
//   stage per quotient bit (QW = 41) gives t*(p1-p0)/denom for both axes, and
//   the output register adds p0 and saturates.
// Stall: each stage holds its item while the next is full and stalled; bubbles
//   close up, and pair.ready drops only when every stage holds an item and
//   result.ready is low. Nothing is lost or repeated.
// Reset: arst_n clears all valid bits at once and sets edge_epsilon to 1; there
//   is no clearing pass, pairs are taken as soon as reset is released.
module segment_intersection_point import sip_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	sip_pair_if.sink     pair,
	sip_result_if.source result,
	sip_cfg_if.sink      cfg
);

	logic [EPS_W-1:0] edge_epsilon_q;

	logic div_valid [QW+1];
	logic div_ready [QW+1];
	div_t div_data  [QW+1];

	// Configuration register
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_epsilon_q <= EPS_RESET;
		end else if (cfg.valid) begin
			edge_epsilon_q <= cfg.data;
		end
	end

	// Products, tests and dividend
	sip_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.pair         (pair),
		.edge_epsilon (edge_epsilon_q),
		.out_valid    (div_valid[0]),
		.out_ready    (div_ready[0]),
		.out_data     (div_data[0])
	);

	// Divider chain, one quotient bit per stage
	for (genvar i = 0; i < QW; i++) begin : g_div
		sip_div_step u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (div_valid[i]),
			.in_ready  (div_ready[i]),
			.in_data   (div_data[i]),
			.out_valid (div_valid[i+1]),
			.out_ready (div_ready[i+1]),
			.out_data  (div_data[i+1])
		);
	end

	// Offset, saturation and result register
	sip_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (div_valid[QW]),
		.in_ready (div_ready[QW]),
		.in_data  (div_data[QW]),
		.result   (result)
	);

	// Checks
`include "assert_macros.svh"

	`ASSERT_IMPL(a_miss_zero_point, result.valid && !result.hit,
		result.cross_x == '0 && result.cross_y == '0, "point not zero without a hit")
	`ASSERT_IMPL(a_div_seed_bound, div_valid[0] && div_data[0].hit,
		div_data[0].lx.rem < div_data[0].dm && div_data[0].ly.rem < div_data[0].dm,
		"divider seed remainder not below divisor")
	`ASSERT_IMPL(a_stall_from_sink, !pair.ready, result.valid && !result.ready,
		"input stalled while output is free")

endmodule

// ----- rtl/sip_front.sv -----
// Front pipeline: differences, cross products, hit tests and the dividend multiply.
module sip_front import sip_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	sip_pair_if.sink         pair,
	input  logic [EPS_W-1:0] edge_epsilon,
	output logic             out_valid,
	input  logic             out_ready,
	output div_t             out_data
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6;

	logic signed [DIFF_W-1:0]  ax_s1, ay_s1, bx_s1, by_s1, cx_s1, cy_s1;
	logic signed [COORD_W-1:0] x0_s1, y0_s1;

	logic signed [PROD_W-1:0]  axby_s2, bxay_s2, axcy_s2, aycx_s2, bxcy_s2, bycx_s2;
	logic signed [DIFF_W-1:0]  ax_s2, ay_s2;
	logic signed [COORD_W-1:0] x0_s2, y0_s2;

	logic signed [NUM_W-1:0]   den_s3, sn_s3, tn_s3;
	logic signed [DIFF_W-1:0]  ax_s3, ay_s3;
	logic signed [COORD_W-1:0] x0_s3, y0_s3;

	logic [MAG_W-1:0]          tm_s4, dm_s4;
	logic [DIFF_W-1:0]         msx_s4, msy_s4;
	logic                      negx_s4, negy_s4, hit_s4;
	logic signed [COORD_W-1:0] x0_s4, y0_s4;

	logic [PPL_W-1:0]          pplx_s5, pply_s5;
	logic [PPH_W-1:0]          pphx_s5, pphy_s5;
	logic [MAG_W-1:0]          dm_s5;
	logic                      negx_s5, negy_s5, hit_s5;
	logic signed [COORD_W-1:0] x0_s5, y0_s5;

	div_t                      dv_s6;

	logic signed [NUM_W-1:0]   eps_w;
	logic                      den_neg, tn_neg, dp, miss, hit_w;
	logic [N_W-1:0]            nx, ny;

	// Stall chain: a stage takes a new item when empty or when the next one moves
	assign rdy_s6     = !v_s6 || out_ready;
	assign rdy_s5     = !v_s5 || rdy_s6;
	assign rdy_s4     = !v_s4 || rdy_s5;
	assign rdy_s3     = !v_s3 || rdy_s4;
	assign rdy_s2     = !v_s2 || rdy_s3;
	assign rdy_s1     = !v_s1 || rdy_s2;
	assign pair.ready = rdy_s1;
	assign out_valid  = v_s6;
	assign out_data   = dv_s6;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= pair.valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
			if (rdy_s6) v_s6 <= v_s5;
		end
	end

	// Stage 1: edge vectors s10, s32 and s02
	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			ax_s1 <= DIFF_W'(pair.first_end_x) - DIFF_W'(pair.first_start_x);
			ay_s1 <= DIFF_W'(pair.first_end_y) - DIFF_W'(pair.first_start_y);
			bx_s1 <= DIFF_W'(pair.second_end_x) - DIFF_W'(pair.second_start_x);
			by_s1 <= DIFF_W'(pair.second_end_y) - DIFF_W'(pair.second_start_y);
			cx_s1 <= DIFF_W'(pair.first_start_x) - DIFF_W'(pair.second_start_x);
			cy_s1 <= DIFF_W'(pair.first_start_y) - DIFF_W'(pair.second_start_y);
			x0_s1 <= pair.first_start_x;
			y0_s1 <= pair.first_start_y;
		end
	end

	// Stage 2: the six cross product terms
	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			axby_s2 <= PROD_W'(ax_s1) * PROD_W'(by_s1);
			bxay_s2 <= PROD_W'(bx_s1) * PROD_W'(ay_s1);
			axcy_s2 <= PROD_W'(ax_s1) * PROD_W'(cy_s1);
			aycx_s2 <= PROD_W'(ay_s1) * PROD_W'(cx_s1);
			bxcy_s2 <= PROD_W'(bx_s1) * PROD_W'(cy_s1);
			bycx_s2 <= PROD_W'(by_s1) * PROD_W'(cx_s1);
			ax_s2   <= ax_s1;
			ay_s2   <= ay_s1;
			x0_s2   <= x0_s1;
			y0_s2   <= y0_s1;
		end
	end

	// Stage 3: denominator and both numerators
	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			den_s3 <= NUM_W'(axby_s2) - NUM_W'(bxay_s2);
			sn_s3  <= NUM_W'(axcy_s2) - NUM_W'(aycx_s2);
			tn_s3  <= NUM_W'(bxcy_s2) - NUM_W'(bycx_s2);
			ax_s3  <= ax_s2;
			ay_s3  <= ay_s2;
			x0_s3  <= x0_s2;
			y0_s3  <= y0_s2;
		end
	end

	// Stage 4: sign-aware range tests, magnitudes and result signs
	assign eps_w   = NUM_W'(edge_epsilon);
	assign den_neg = den_s3[NUM_W-1];
	assign tn_neg  = tn_s3[NUM_W-1];
	assign dp      = !den_neg;
	assign miss    = ((sn_s3 < eps_w) == dp) || ((tn_s3 < eps_w) == dp) ||
		((den_s3 < sn_s3) == dp) || ((den_s3 < tn_s3) == dp);
	assign hit_w   = (den_s3 != '0) && !miss;

	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			tm_s4   <= tn_neg ? MAG_W'(-tn_s3) : MAG_W'(tn_s3);
			dm_s4   <= den_neg ? MAG_W'(-den_s3) : MAG_W'(den_s3);
			msx_s4  <= ax_s3[DIFF_W-1] ? DIFF_W'(-ax_s3) : DIFF_W'(ax_s3);
			msy_s4  <= ay_s3[DIFF_W-1] ? DIFF_W'(-ay_s3) : DIFF_W'(ay_s3);
			negx_s4 <= (tn_neg ^ den_neg) ^ ax_s3[DIFF_W-1];
			negy_s4 <= (tn_neg ^ den_neg) ^ ay_s3[DIFF_W-1];
			hit_s4  <= hit_w;
			x0_s4   <= x0_s3;
			y0_s4   <= y0_s3;
		end
	end

	// Stage 5: |t_numer| * |s| as two partial products per axis
	always_ff @(posedge clk) begin
		if (rdy_s5) begin
			pplx_s5 <= PPL_W'(tm_s4[PP_LO_W-1:0]) * PPL_W'(msx_s4);
			pphx_s5 <= PPH_W'(tm_s4[MAG_W-1:PP_LO_W]) * PPH_W'(msx_s4);
			pply_s5 <= PPL_W'(tm_s4[PP_LO_W-1:0]) * PPL_W'(msy_s4);
			pphy_s5 <= PPH_W'(tm_s4[MAG_W-1:PP_LO_W]) * PPH_W'(msy_s4);
			dm_s5   <= dm_s4;
			negx_s5 <= negx_s4;
			negy_s5 <= negy_s4;
			hit_s5  <= hit_s4;
			x0_s5   <= x0_s4;
			y0_s5   <= y0_s4;
		end
	end

	// Stage 6: combine partial products and seed the divider
	assign nx = N_W'(pplx_s5) + (N_W'(pphx_s5) << PP_LO_W);
	assign ny = N_W'(pply_s5) + (N_W'(pphy_s5) << PP_LO_W);

	always_ff @(posedge clk) begin
		if (rdy_s6) begin
			dv_s6.lx.rem  <= MAG_W'(nx[N_W-1:QW]);
			dv_s6.lx.work <= nx[QW-1:0];
			dv_s6.ly.rem  <= MAG_W'(ny[N_W-1:QW]);
			dv_s6.ly.work <= ny[QW-1:0];
			dv_s6.dm      <= dm_s5;
			dv_s6.neg_x   <= negx_s5;
			dv_s6.neg_y   <= negy_s5;
			dv_s6.hit     <= hit_s5;
			dv_s6.x0      <= x0_s5;
			dv_s6.y0      <= y0_s5;
		end
	end

endmodule

// ----- rtl/sip_div_step.sv -----
// One restoring division stage: yields one quotient bit for each axis.
module sip_div_step import sip_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  div_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output div_t out_data
);

	logic valid_sd;
	div_t data_sd;
	div_t next_w;

	// Shift in the next dividend bit, subtract the divisor when it fits
	function automatic lane_t step_lane(input lane_t l, input logic [MAG_W-1:0] dm);
		logic [MAG_W:0] trial;
		logic [MAG_W:0] diff;
		logic           ge;
		lane_t          r;
		trial  = {l.rem, l.work[QW-1]};
		diff   = trial - {1'b0, dm};
		ge     = (trial >= {1'b0, dm});
		r.rem  = ge ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
		r.work = {l.work[QW-2:0], ge};
		return r;
	endfunction

	always_comb begin
		next_w    = in_data;
		next_w.lx = step_lane(in_data.lx, in_data.dm);
		next_w.ly = step_lane(in_data.ly, in_data.dm);
	end

	assign in_ready  = !valid_sd || out_ready;
	assign out_valid = valid_sd;
	assign out_data  = data_sd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sd <= 1'b0;
		end else if (in_ready) begin
			valid_sd <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			data_sd <= next_w;
		end
	end

endmodule

// ----- rtl/sip_back.sv -----
// Output stage: signed offset, add to p0, saturate, and the result register.
module sip_back import sip_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  div_t        in_data,
	sip_result_if.source result
);

	localparam logic signed [SUM_W-1:0] SUM_MAX =
		{{(SUM_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN = ~SUM_MAX;

	logic                      out_valid_q;
	logic                      hit_q;
	logic signed [COORD_W-1:0] cross_x_q, cross_y_q;

	logic signed [OFF_W-1:0]   qx, qy, offx, offy;
	logic signed [SUM_W-1:0]   sumx, sumy;

	// Clamp to the signed coordinate range
	function automatic logic signed [COORD_W-1:0] sat(input logic signed [SUM_W-1:0] s);
		logic signed [SUM_W-1:0] c;
		if (s > SUM_MAX) begin
			c = SUM_MAX;
		end else if (s < SUM_MIN) begin
			c = SUM_MIN;
		end else begin
			c = s;
		end
		return c[COORD_W-1:0];
	endfunction

	// Quotient with its sign, then p0 plus offset
	assign qx   = OFF_W'(in_data.lx.work);
	assign qy   = OFF_W'(in_data.ly.work);
	assign offx = in_data.neg_x ? -qx : qx;
	assign offy = in_data.neg_y ? -qy : qy;
	assign sumx = SUM_W'(in_data.x0) + SUM_W'(offx);
	assign sumy = SUM_W'(in_data.y0) + SUM_W'(offy);

	assign in_ready       = !out_valid_q || result.ready;
	assign result.valid   = out_valid_q;
	assign result.hit     = hit_q;
	assign result.cross_x = cross_x_q;
	assign result.cross_y = cross_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	// Point is zero when there is no hit
	always_ff @(posedge clk) begin
		if (in_ready) begin
			hit_q     <= in_data.hit;
			cross_x_q <= in_data.hit ? sat(sumx) : '0;
			cross_y_q <= in_data.hit ? sat(sumy) : '0;
		end
	end

endmodule

// ----- bench/segment_intersection_point_tb.sv -----
// Self-checking testbench for the segment intersection block.
`timescale 1ns / 1ps

module segment_intersection_point_tb;
	import sip_pkg::*;

	localparam int PIPE_LATENCY = 6 + QW + 1;
	localparam int DRAIN_CYCLES = PIPE_LATENCY + 8;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int REPORT_LIMIT = 10;
	localparam int COORD_MAX    = (1 << (COORD_W - 1)) - 1;
	localparam int COORD_MIN    = -(1 << (COORD_W - 1));

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [127:0]       wide_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
	} point_t;

	typedef struct packed {
		point_t p0;
		point_t p1;
		point_t p2;
		point_t p3;
	} seg_pair_t;

	typedef struct packed {
		logic   hit;
		coord_t x;
		coord_t y;
	} crossing_t;

	logic clk = 1'b0;
	logic arst_n;

	sip_pair_if   pair_ch ();
	sip_result_if res_ch ();
	sip_cfg_if    cfg_ch ();

	segment_intersection_point DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.pair   (pair_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	// Predictor copy of the threshold register
	logic [EPS_W-1:0] edge_eps = EPS_RESET;

	crossing_t expected_crossings[$];
	int        mismatches    = 0;
	int        cycle_count   = 0;
	int        send_gap_pct  = 0;
	int        recv_idle_pct = 0;
	int        hold_request  = 0;

	always #10 clk = ~clk;

	// Run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Clamp to the signed coordinate range
	function automatic coord_t saturate_coord(input longint v);
		if (v > COORD_MAX)
			return coord_t'(COORD_MAX);
		if (v < COORD_MIN)
			return coord_t'(COORD_MIN);
		return coord_t'(v);
	endfunction

	// Expected crossing for one segment pair under the current threshold
	function automatic crossing_t predict_crossing(input seg_pair_t sp);
		longint    ax, ay, bx, by, cx, cy;
		longint    den, s_num, t_num, eps;
		wide_t     off_x, off_y;
		bit        den_pos;
		crossing_t r;
		r = '0;
		ax = longint'(sp.p1.x) - longint'(sp.p0.x);
		ay = longint'(sp.p1.y) - longint'(sp.p0.y);
		bx = longint'(sp.p3.x) - longint'(sp.p2.x);
		by = longint'(sp.p3.y) - longint'(sp.p2.y);
		cx = longint'(sp.p0.x) - longint'(sp.p2.x);
		cy = longint'(sp.p0.y) - longint'(sp.p2.y);
		den = ax * by - bx * ay;
		// parallel or degenerate
		if (den == 0)
			return r;
		den_pos = den > 0;
		s_num = ax * cy - ay * cx;
		t_num = bx * cy - by * cx;
		eps = longint'(edge_eps);
		if (((s_num < eps) == den_pos) || ((t_num < eps) == den_pos) ||
			((den < s_num) == den_pos) || ((den < t_num) == den_pos))
			return r;
		// signed division truncates toward zero
		off_x = (wide_t'(t_num) * wide_t'(ax)) / wide_t'(den);
		off_y = (wide_t'(t_num) * wide_t'(ay)) / wide_t'(den);
		r.hit = 1'b1;
		r.x = saturate_coord(longint'(sp.p0.x) + longint'(off_x));
		r.y = saturate_coord(longint'(sp.p0.y) + longint'(off_y));
		return r;
	endfunction

	// Result checker
	always @(posedge clk) begin
		crossing_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (expected_crossings.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("unexpected item: hit %0b x %0d y %0d",
						res_ch.hit, res_ch.cross_x, res_ch.cross_y);
			end else begin
				want = expected_crossings.pop_front();
				if (res_ch.hit !== want.hit || res_ch.cross_x !== want.x ||
					res_ch.cross_y !== want.y) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("mismatch: got hit %0b x %0d y %0d, exp hit %0b x %0d y %0d",
							res_ch.hit, res_ch.cross_x, res_ch.cross_y,
							want.hit, want.x, want.y);
				end
			end
		end
	end

	// Receiver: random stalls, plus a long hold-off on request
	initial begin
		int hold_left;
		hold_left = 0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Offer one pair, with random idle cycles first; valid stays high afterwards
	task automatic send_pair(input seg_pair_t sp);
		while ($urandom_range(99) < send_gap_pct) begin
			pair_ch.valid <= 1'b0;
			@(posedge clk);
		end
		pair_ch.valid          <= 1'b1;
		pair_ch.first_start_x  <= sp.p0.x;
		pair_ch.first_start_y  <= sp.p0.y;
		pair_ch.first_end_x    <= sp.p1.x;
		pair_ch.first_end_y    <= sp.p1.y;
		pair_ch.second_start_x <= sp.p2.x;
		pair_ch.second_start_y <= sp.p2.y;
		pair_ch.second_end_x   <= sp.p3.x;
		pair_ch.second_end_y   <= sp.p3.y;
		do
			@(posedge clk);
		while (!pair_ch.ready);
		expected_crossings.push_back(predict_crossing(sp));
	endtask

	task automatic send_coords(input int x0, y0, x1, y1, x2, y2, x3, y3);
		seg_pair_t sp;
		sp.p0 = '{x: coord_t'(x0), y: coord_t'(y0)};
		sp.p1 = '{x: coord_t'(x1), y: coord_t'(y1)};
		sp.p2 = '{x: coord_t'(x2), y: coord_t'(y2)};
		sp.p3 = '{x: coord_t'(x3), y: coord_t'(y3)};
		send_pair(sp);
	endtask

	// Stop offering and let the pipeline empty
	task automatic settle();
		pair_ch.valid <= 1'b0;
		while (expected_crossings.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_epsilon(input logic [EPS_W-1:0] value);
		settle();
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= value;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		edge_eps = value;
	endtask

	function automatic point_t any_point();
		return '{x: coord_t'($urandom()), y: coord_t'($urandom())};
	endfunction

	function automatic point_t near_point(input int span);
		return '{x: coord_t'(int'($urandom_range(0, 2 * span)) - span),
			y: coord_t'(int'($urandom_range(0, 2 * span)) - span)};
	endfunction

	// Random pair: mix of free and near placement, crossing diagonals, parallel, touching and collapsed cases
	function automatic seg_pair_t random_pair();
		seg_pair_t sp;
		int        kind, span, k;
		kind = $urandom_range(9);
		span = 1 << $urandom_range(2, 12);
		sp.p0 = any_point();
		sp.p1 = any_point();
		sp.p2 = any_point();
		sp.p3 = any_point();
		case (kind)
			3, 4, 6, 7: begin
				sp.p0 = near_point(span);
				sp.p1 = near_point(span);
				sp.p2 = near_point(span);
				sp.p3 = near_point(span);
			end
			default: ;
		endcase
		case (kind)
			// diagonals of one rectangle, which cross unless it has zero width or height
			5, 6: begin
				sp.p2 = '{x: sp.p0.x, y: sp.p1.y};
				sp.p3 = '{x: sp.p1.x, y: sp.p0.y};
			end
			// parallel, scaled copy of segment one; a scale of zero collapses it to a point
			7: begin
				k = int'($urandom_range(0, 4)) - 2;
				sp.p3.x = coord_t'(int'(sp.p2.x) + k * (int'(sp.p1.x) - int'(sp.p0.x)));
				sp.p3.y = coord_t'(int'(sp.p2.y) + k * (int'(sp.p1.y) - int'(sp.p0.y)));
			end
			// shared endpoint
			8: sp.p2 = $urandom_range(1) ? sp.p0 : sp.p1;
			// segment one collapsed to a point
			9: sp.p1 = sp.p0;
			default: ;
		endcase
		return sp;
	endfunction

	// Hand-picked geometry at the reset threshold
	task automatic test_directed_geometry();
		send_gap_pct  = 0;
		recv_idle_pct = 0;
		send_coords(0, 0, 0, 0, 0, 0, 0, 0);
		send_coords(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
			COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
		send_coords(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
			COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
		send_coords(-1000, -1000, 1000, 1000, -1000, 1000, 1000, -1000);
		// half-way crossings that need truncation, both directions
		send_coords(0, 0, 7, 3, 0, 3, 7, 0);
		send_coords(7, 3, 0, 0, 0, 3, 7, 0);
		// parallel, collinear, degenerate
		send_coords(0, 0, 100, 0, 0, 10, 100, 10);
		send_coords(0, 0, 100, 0, 50, 0, 150, 0);
		send_coords(5, 5, 5, 5, 0, 10, 10, 0);
		// lines cross beyond segment one, then beyond segment two
		send_coords(0, 0, 10, 10, 30, 0, 0, 30);
		send_coords(0, 0, 100, 100, 100, 0, 80, 20);
		// end of segment one touches segment two, then its start does
		send_coords(0, 0, 50, 50, 0, 100, 100, 0);
		send_coords(50, 50, 100, 100, 0, 100, 100, 0);
		// positive and negative denominators, up to the coordinate extremes
		send_coords(-1000, -1000, 1000, 1000, 1000, -1000, -1000, 1000);
		send_coords(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
			COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN);
		send_coords(COORD_MIN, 0, COORD_MAX, 0, 0, COORD_MIN, 0, COORD_MAX);
		send_coords(24'h555555, 24'haaaaaa, 24'haaaaaa, 24'h555555,
			24'h555555, 24'h555555, 24'haaaaaa, 24'haaaaaa);
	endtask

	// Threshold at both ends; a wide threshold lets a near-parallel miss
	// extrapolate past the coordinate range, so the point saturates
	task automatic test_epsilon_extremes();
		write_epsilon(16'hffff);
		send_coords(8388000, 0, 8387999, 0, 8369000, 100, 8368800, 101);
		send_coords(-8388000, 0, -8387999, 0, -8369000, -100, -8368800, -101);
		send_coords(0, 0, 50, 50, 0, 100, 100, 0);
		send_coords(-1000, -1000, 1000, 1000, -1000, 1000, 1000, -1000);
		write_epsilon('0);
		send_coords(50, 50, 100, 100, 0, 100, 100, 0);
		send_coords(0, 0, 50, 50, 0, 100, 100, 0);
		send_coords(-1000, -1000, 1000, 1000, -1000, 1000, 1000, -1000);
		send_coords(COORD_MIN, 0, COORD_MAX, 0, 0, COORD_MIN, 0, COORD_MAX);
	endtask

	task automatic test_random_traffic(input int count, input int tx_idle, input int rx_idle,
		input logic [EPS_W-1:0] eps);
		write_epsilon(eps);
		send_gap_pct  = tx_idle;
		recv_idle_pct = rx_idle;
		repeat (count) send_pair(random_pair());
	endtask

	// Long receiver hold-off while pairs keep coming, so the pipeline fills
	task automatic test_output_backpressure();
		settle();
		send_gap_pct  = 0;
		recv_idle_pct = 0;
		hold_request  = 4 * PIPE_LATENCY;
		repeat (80) send_pair(random_pair());
	endtask

	initial begin
		arst_n = 1'b0;
		pair_ch.valid          <= 1'b0;
		pair_ch.first_start_x  <= '0;
		pair_ch.first_start_y  <= '0;
		pair_ch.first_end_x    <= '0;
		pair_ch.first_end_y    <= '0;
		pair_ch.second_start_x <= '0;
		pair_ch.second_start_y <= '0;
		pair_ch.second_end_x   <= '0;
		pair_ch.second_end_y   <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.data  <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_geometry();
		test_epsilon_extremes();
		test_random_traffic(110, 27, 55, 16'd16);
		test_random_traffic(110, 55, 27, 16'($urandom_range(0, 65535)));
		test_random_traffic(110, 0, 0, 16'd1);
		test_output_backpressure();

		settle();
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/sip_pkg.sv
rtl/sip_ifs.sv
rtl/sip_front.sv
rtl/sip_div_step.sv
rtl/sip_back.sv
rtl/segment_intersection_point.sv
bench/segment_intersection_point_tb.sv
